>>> hw/rtl/lcrf_pkg.sv
package lcrf_pkg;

    localparam int VALUE_BITS   = 31;
    localparam int MAX_ELEMENTS = 16384;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ELEMENTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ELEMENTS - 1);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last_element;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] run_start;
        logic [IDX_W-1:0] run_stop;
        logic [CNT_W-1:0] run_length;
        logic             overflow;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture operands of the accepted transaction
        logic step;    // one binary GCD iteration
        logic commit;  // update run bookkeeping, emit result if last
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic gcd_done;
        logic last;
    } t_status;

endpackage

>>> hw/rtl/lcrf_dp.sv
module lcrf_dp
    import lcrf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_data,
    output t_status   o_status,
    output t_out_item o_out_data
);

    logic [VALUE_BITS-1:0] r_a, r_b, r_prev;
    logic                  r_last;
    logic [CNT_W-1:0]      r_pos, r_cur, r_best;
    logic [IDX_W-1:0]      r_bstart, r_bstop;
    logic                  r_ovf;
    t_out_item             r_out;

    logic                  a_zero, b_zero, both_even, ab_eq, coprime;
    logic [VALUE_BITS-1:0] diff_ab, diff_ba;
    logic                  pos_sat;
    logic [IDX_W-1:0]      idx;
    logic [CNT_W-1:0]      idx_p1;
    logic [CNT_W-1:0]      run_inc;
    logic [CNT_W-1:0]      n_cur, n_best;
    logic [IDX_W-1:0]      n_bstart, n_bstop;
    logic [CNT_W-1:0]      n_pos;
    logic                  n_ovf;

    // binary GCD: only "is the GCD one" matters
    assign a_zero    = (r_a == '0);
    assign b_zero    = (r_b == '0);
    assign both_even = !r_a[0] && !r_b[0];
    assign ab_eq     = (r_a == r_b);
    assign diff_ab   = r_a - r_b;
    assign diff_ba   = r_b - r_a;

    always_comb begin
        if (a_zero) begin
            coprime = (r_b == VALUE_BITS'(1));
        end else if (b_zero) begin
            coprime = (r_a == VALUE_BITS'(1));
        end else if (both_even) begin
            coprime = 1'b0;
        end else begin
            coprime = ab_eq && (r_a == VALUE_BITS'(1));
        end
    end

    assign o_status.gcd_done = a_zero || b_zero || both_even || ab_eq;
    assign o_status.last     = r_last;

    // index and run bookkeeping
    assign pos_sat = (r_pos >= MAX_CNT);
    assign idx     = pos_sat ? IDX_LAST : r_pos[IDX_W-1:0];
    assign idx_p1  = {1'b0, idx} + CNT_W'(1);
    assign run_inc = (r_cur < MAX_CNT) ? r_cur + CNT_W'(1) : r_cur;
    assign n_pos   = pos_sat ? r_pos : r_pos + CNT_W'(1);
    assign n_ovf   = r_ovf | pos_sat;

    always_comb begin
        n_cur    = CNT_W'(1);
        n_best   = r_best;
        n_bstart = r_bstart;
        n_bstop  = r_bstop;
        if (coprime) begin
            n_cur = run_inc;
            if (run_inc > r_best) begin
                n_best   = run_inc;
                n_bstart = (idx_p1 >= run_inc) ? IDX_W'(idx_p1 - run_inc) : '0;
                n_bstop  = idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_in_data.value;
            r_b <= r_prev;
        end else if (i_cmd.step) begin
            if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a > r_b) begin
                r_a <= diff_ab >> 1;
            end else begin
                r_b <= diff_ba >> 1;
            end
        end
        if (i_cmd.commit && r_last) begin
            r_out.run_start  <= n_bstart;
            r_out.run_stop   <= n_bstop;
            r_out.run_length <= n_best;
            r_out.overflow   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_last   <= 1'b0;
            r_pos    <= '0;
            r_cur    <= '0;
            r_best   <= '0;
            r_bstart <= '0;
            r_bstop  <= '0;
            r_ovf    <= 1'b0;
        end else if (i_cmd.load) begin
            r_prev <= i_in_data.value;
            r_last <= i_in_data.last_element;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                r_prev   <= '0;
                r_pos    <= '0;
                r_cur    <= '0;
                r_best   <= '0;
                r_bstart <= '0;
                r_bstop  <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_pos    <= n_pos;
                r_cur    <= n_cur;
                r_best   <= n_best;
                r_bstart <= n_bstart;
                r_bstop  <= n_bstop;
                r_ovf    <= n_ovf;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

>>> hw/rtl/lcrf_ctrl.sv
module lcrf_ctrl
    import lcrf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_GCD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // output register can take a result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_GCD;
                end
            end
            S_GCD: begin
                if (!i_status.gcd_done) begin
                    o_cmd.step = 1'b1;
                end else if (!i_status.last || out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                    if (i_status.last) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/longest_coprime_run_finder.sv
// Sequence: load the input transaction, run binary GCD iterations until the
// GCD is settled, then commit (run state; result register on a last element).
// A new transaction is taken only after the commit; a last-element commit
// also waits while a stalled result holds the output register.
// Each GCD iteration strips at least one bit from one operand.
// Reset: synchronous, active low; clears run state, index and overflow flag.
module longest_coprime_run_finder
    import lcrf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_cmd    cmd;
    t_status status;

    // Controller: idle/GCD sequencer plus the result-valid flag. A finished
    // result may sit in the output register while the next element is taken;
    // only a last-element commit waits for that register to drain.
    lcrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: GCD operand pair, previous element, saturating index,
    // current/best run tracking and the result register.
    lcrf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

    // An accepted transaction always occupies the engine for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("engine not busy after input transaction");

    // A new result only appears at the end of a busy period.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised without a commit");

    // Reported run lies inside the index range and is ordered.
    a_run_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.run_length <= MAX_CNT) &&
                        (o_out_data.run_stop >= o_out_data.run_start))
        else $error("result run out of bounds");

endmodule
